### rtl/otsb_pkg.sv
// otsb_pkg: command and expiry transaction types and command kind codes
// for the one-shot timer bank; no dependencies
package otsb_pkg;

    localparam logic [1:0] KIND_TICK  = 2'd0;
    localparam logic [1:0] KIND_START = 2'd1;
    localparam logic [1:0] KIND_STOP  = 2'd2;
    localparam logic [1:0] KIND_CLEAR = 2'd3;

    localparam int TIMER_ID_W = 8;
    localparam int TIMEOUT_W  = 32;
    localparam int EXP_ID_W   = 6;

    typedef struct packed {
        logic [1:0]            kind;
        logic [TIMER_ID_W-1:0] timer_id;
        logic [TIMEOUT_W-1:0]  timeout;
    } cmd_t;

    typedef struct packed {
        logic [EXP_ID_W-1:0] expired_id;
        logic                last;
    } expiry_t;

endpackage

### rtl/one_shot_timer_bank_unit.sv
// one_shot_timer_bank_unit: bank of one-shot countdown timers; start, stop and clear
// commands are handled in the idle state, a tick walks the bank with one shared decrementer
// handshake: start, stop, clear accepted every cycle while idle; a tick holds cmd_ready low
// while it walks the bank (a read state per timer, a decrement state per armed timer,
// then a flush state), and the walk stalls while expiry_ready holds back an expiry
// reset: rst_n async active low disarms all timers; counts are not cleared
module one_shot_timer_bank_unit #(
    parameter int NUM_TIMERS = 8
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cmd_valid,
    output logic            cmd_ready,
    input  otsb_pkg::cmd_t  cmd,
    output logic            expiry_valid,
    input  logic            expiry_ready,
    output otsb_pkg::expiry_t expiry
);
    import otsb_pkg::*;

    localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_TIMERS - 1);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_READ  = 2'd1;
    localparam logic [1:0] S_EXEC  = 2'd2;
    localparam logic [1:0] S_FLUSH = 2'd3;

    logic [1:0]            state_reg, state_next;
    logic [IDX_W-1:0]      idx_reg, idx_next;
    logic [NUM_TIMERS-1:0] armed_reg, armed_next;
    logic                  pend_valid_reg, pend_valid_next;
    logic [IDX_W-1:0]      pend_id_reg, pend_id_next;
    logic                  expiry_valid_reg, expiry_valid_next;
    expiry_t               expiry_reg, expiry_next;

    logic [TIMEOUT_W-1:0]  mem [NUM_TIMERS];
    logic [TIMEOUT_W-1:0]  rd_data_reg;

    logic                  mem_we;
    logic [IDX_W-1:0]      mem_waddr;
    logic [TIMEOUT_W-1:0]  mem_wdata;

    logic [TIMEOUT_W-1:0]  dec_value;
    logic                  dec_zero;
    logic                  cmd_fire;
    logic                  id_ok;
    logic [IDX_W-1:0]      cmd_idx;

    assign cmd_ready    = (state_reg == S_IDLE);
    assign cmd_fire     = cmd_valid && cmd_ready;
    assign id_ok        = (cmd.timer_id < TIMER_ID_W'(NUM_TIMERS));
    assign cmd_idx      = cmd.timer_id[IDX_W-1:0];
    assign dec_value    = rd_data_reg - TIMEOUT_W'(1);
    assign dec_zero     = (dec_value == '0);
    assign expiry_valid = expiry_valid_reg;
    assign expiry       = expiry_reg;

    always_comb
    begin
        state_next        = state_reg;
        idx_next          = idx_reg;
        armed_next        = armed_reg;
        pend_valid_next   = pend_valid_reg;
        pend_id_next      = pend_id_reg;
        expiry_valid_next = expiry_valid_reg && !expiry_ready;
        expiry_next       = expiry_reg;
        mem_we            = 1'b0;
        mem_waddr         = idx_reg;
        mem_wdata         = dec_value;

        case (state_reg)
            S_IDLE:
            begin
                if (cmd_fire)
                begin
                    case (cmd.kind)
                        KIND_START:
                        begin
                            if (id_ok && (cmd.timeout != '0))
                            begin
                                mem_we              = 1'b1;
                                mem_waddr           = cmd_idx;
                                mem_wdata           = cmd.timeout;
                                armed_next[cmd_idx] = 1'b1;
                            end
                        end
                        KIND_STOP:
                        begin
                            if (id_ok)
                                armed_next[cmd_idx] = 1'b0;
                        end
                        KIND_CLEAR:
                        begin
                            armed_next = '0;
                        end
                        default:
                        begin
                            idx_next   = '0;
                            state_next = S_READ;
                        end
                    endcase
                end
            end
            S_READ:
            begin
                if (armed_reg[idx_reg])
                    state_next = S_EXEC;
                else if (idx_reg == LAST_IDX)
                    state_next = S_FLUSH;
                else
                    idx_next = idx_reg + IDX_W'(1);
            end
            S_EXEC:
            begin
                // hold while an older expiry cannot yet move to the output register
                if (!(dec_zero && pend_valid_reg && expiry_valid_reg && !expiry_ready))
                begin
                    mem_we = 1'b1;
                    if (dec_zero)
                    begin
                        armed_next[idx_reg] = 1'b0;
                        if (pend_valid_reg)
                        begin
                            expiry_valid_next      = 1'b1;
                            expiry_next.expired_id = EXP_ID_W'(pend_id_reg);
                            expiry_next.last       = 1'b0;
                        end
                        pend_valid_next = 1'b1;
                        pend_id_next    = idx_reg;
                    end
                    if (idx_reg == LAST_IDX)
                        state_next = S_FLUSH;
                    else
                    begin
                        idx_next   = idx_reg + IDX_W'(1);
                        state_next = S_READ;
                    end
                end
            end
            S_FLUSH:
            begin
                if (!pend_valid_reg)
                    state_next = S_IDLE;
                else if (!expiry_valid_reg || expiry_ready)
                begin
                    expiry_valid_next      = 1'b1;
                    expiry_next.expired_id = EXP_ID_W'(pend_id_reg);
                    expiry_next.last       = 1'b1;
                    pend_valid_next        = 1'b0;
                    state_next             = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            idx_reg          <= '0;
            armed_reg        <= '0;
            pend_valid_reg   <= 1'b0;
            expiry_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            idx_reg          <= idx_next;
            armed_reg        <= armed_next;
            pend_valid_reg   <= pend_valid_next;
            expiry_valid_reg <= expiry_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_id_reg <= pend_id_next;
        expiry_reg  <= expiry_next;
    end

    // count store, one write port and one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        rd_data_reg <= mem[idx_reg];
    end

endmodule

### rtl/otsb_checker.sv
// otsb_checker: port-level assertions for one_shot_timer_bank_unit,
// bound to the top level; depends on otsb_pkg
module otsb_checker #(
    parameter int NUM_TIMERS = 8
) (
    input logic              clk,
    input logic              rst_n,
    input logic              cmd_valid,
    input logic              cmd_ready,
    input otsb_pkg::cmd_t    cmd,
    input logic              expiry_valid,
    input logic              expiry_ready,
    input otsb_pkg::expiry_t expiry
);
    import otsb_pkg::*;

    // a stalled expiry transaction holds
    a_expiry_hold: assert property (@(posedge clk) disable iff (!rst_n)
        expiry_valid && !expiry_ready |=> expiry_valid && $stable(expiry))
        else $error("expiry transaction changed while stalled");

    // a tick walks the bank, so the command side is closed in the cycle after the tick is accepted
    a_tick_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_ready && (cmd.kind == KIND_TICK) |=> !cmd_ready)
        else $error("command accepted right after a tick");

    // start, stop and clear leave the command side open in the cycle after they are accepted
    a_cmd_single: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_ready && (cmd.kind != KIND_TICK) |=> cmd_ready)
        else $error("non-tick command left the unit busy");

    // expiries only come out of a tick walk and name an existing timer
    a_expiry_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(expiry_valid) |-> $past(!cmd_ready)
            && ({1'b0, expiry.expired_id} < 7'(NUM_TIMERS)))
        else $error("expiry outside a tick walk or bad timer id");

endmodule

bind one_shot_timer_bank_unit otsb_checker #(
    .NUM_TIMERS(NUM_TIMERS)
) u_otsb_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd_valid    (cmd_valid),
    .cmd_ready    (cmd_ready),
    .cmd          (cmd),
    .expiry_valid (expiry_valid),
    .expiry_ready (expiry_ready),
    .expiry       (expiry)
);

### sim/testbench.sv
// testbench: self-checking bench for the one-shot timer bank, with an internal
// predictor of the timer counts and a scoreboard of expected expiry transactions
// depends on otsb_pkg and one_shot_timer_bank_unit
module testbench;
    import otsb_pkg::*;

    localparam int NUM_TIMERS = 8;
    localparam int HOLD_LEN   = 400;
    localparam int CYCLE_MAX  = 400000;

    logic    clk = 1'b0;
    logic    rst_n = 1'b0;
    logic    cmd_valid = 1'b0;
    logic    cmd_ready;
    cmd_t    cmd = '0;
    logic    expiry_valid;
    logic    expiry_ready = 1'b0;
    expiry_t expiry;

    cmd_t    pending_cmds[$];
    expiry_t expected_expiries[$];

    logic [TIMEOUT_W-1:0] tmr_count[NUM_TIMERS];
    logic                 tmr_armed[NUM_TIMERS];

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int errors = 0;
    int cmds_done = 0;
    int ticks_done = 0;
    int expiries_seen = 0;
    int cycle_count = 0;

    logic hold_request = 1'b0;
    logic receiver_hold = 1'b0;
    int   hold_cycles = 0;

    one_shot_timer_bank_unit #(
        .NUM_TIMERS(NUM_TIMERS)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .cmd_valid(cmd_valid),
        .cmd_ready(cmd_ready),
        .cmd(cmd),
        .expiry_valid(expiry_valid),
        .expiry_ready(expiry_ready),
        .expiry(expiry)
    );

    always #5 clk = ~clk;

    // predictor: applies one accepted command to the model of the bank
    function void advance_bank(cmd_t c);
        expiry_t e;
        int      n;
        n = 0;
        case (c.kind)
            KIND_START:
            begin
                if (c.timer_id < NUM_TIMERS && c.timeout != '0)
                begin
                    tmr_count[c.timer_id] = c.timeout;
                    tmr_armed[c.timer_id] = 1'b1;
                end
            end
            KIND_STOP:
            begin
                if (c.timer_id < NUM_TIMERS)
                    tmr_armed[c.timer_id] = 1'b0;
            end
            KIND_CLEAR:
            begin
                for (int i = 0; i < NUM_TIMERS; i++)
                    tmr_armed[i] = 1'b0;
            end
            default:
            begin
                ticks_done++;
                for (int i = 0; i < NUM_TIMERS; i++)
                begin
                    if (tmr_armed[i])
                    begin
                        tmr_count[i] = tmr_count[i] - 1'b1;
                        if (tmr_count[i] == '0)
                        begin
                            tmr_armed[i] = 1'b0;
                            e.expired_id = i[EXP_ID_W-1:0];
                            e.last = 1'b0;
                            expected_expiries.push_back(e);
                            n++;
                        end
                    end
                end
                if (n > 0)
                    expected_expiries[expected_expiries.size()-1].last = 1'b1;
            end
        endcase
    endfunction

    function cmd_t make_random_cmd();
        cmd_t c;
        int   pick;
        c.timer_id = 8'($urandom);
        c.timeout = $urandom;
        pick = $urandom_range(99);
        if (pick < 42)
            c.kind = KIND_TICK;
        else if (pick < 80)
        begin
            c.kind = KIND_START;
            if ($urandom_range(9) != 0)
                c.timer_id = 8'($urandom_range(NUM_TIMERS-1));
            pick = $urandom_range(19);
            if (pick < 16)
                c.timeout = $urandom_range(12, 1);
            else if (pick < 18)
                c.timeout = '0;
        end
        else if (pick < 96)
        begin
            c.kind = KIND_STOP;
            if ($urandom_range(9) != 0)
                c.timer_id = 8'($urandom_range(NUM_TIMERS-1));
        end
        else
            c.kind = KIND_CLEAR;
        return c;
    endfunction

    // command driver
    always @(posedge clk)
    begin : cmd_driver
        logic held;
        if (!rst_n)
            cmd_valid <= 1'b0;
        else
        begin
            held = cmd_valid;
            if (cmd_valid && cmd_ready)
            begin
                advance_bank(cmd);
                void'(pending_cmds.pop_front());
                cmds_done++;
                held = 1'b0;
            end
            if (!held)
            begin
                if (pending_cmds.size() > 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    cmd_valid <= 1'b1;
                    cmd <= pending_cmds[0];
                end
                else
                    cmd_valid <= 1'b0;
            end
        end
    end

    // long receiver hold-off
    always @(posedge clk)
    begin
        if (hold_request)
        begin
            receiver_hold <= 1'b1;
            hold_cycles <= HOLD_LEN;
        end
        else if (receiver_hold)
        begin
            if (hold_cycles == 1)
                receiver_hold <= 1'b0;
            hold_cycles <= hold_cycles - 1;
        end
    end

    always @(posedge clk)
        expiry_ready <= rst_n && !receiver_hold && ($urandom_range(99) >= recv_stall_pct);

    // expiry monitor
    always @(posedge clk)
    begin : expiry_monitor
        expiry_t want;
        if (rst_n && expiry_valid && expiry_ready)
        begin
            expiries_seen++;
            if (expected_expiries.size() == 0)
            begin
                $display("%0t: unexpected expiry transaction, expected none, actual id=%0d last=%0b",
                         $time, expiry.expired_id, expiry.last);
                errors++;
            end
            else
            begin
                want = expected_expiries.pop_front();
                if (expiry.expired_id !== want.expired_id)
                begin
                    $display("%0t: expired_id mismatch, expected %0d, actual %0d",
                             $time, want.expired_id, expiry.expired_id);
                    errors++;
                end
                if (expiry.last !== want.last)
                begin
                    $display("%0t: last mismatch (id %0d), expected %0b, actual %0b",
                             $time, want.expired_id, want.last, expiry.last);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        while (cycle_count < CYCLE_MAX)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Mismatches found");
        $finish;
    end

    task automatic queue_cmd(logic [1:0] k, logic [TIMER_ID_W-1:0] id,
                             logic [TIMEOUT_W-1:0] tmo);
        cmd_t c;
        c.kind = k;
        c.timer_id = id;
        c.timeout = tmo;
        pending_cmds.push_back(c);
    endtask

    task automatic wait_drained();
        while (pending_cmds.size() > 0 || expected_expiries.size() > 0)
            @(negedge clk);
    endtask

    task automatic run_phase(int send_pct, int recv_pct, int count);
        send_idle_pct = send_pct;
        recv_stall_pct = recv_pct;
        for (int i = 0; i < count; i++)
            pending_cmds.push_back(make_random_cmd());
        wait_drained();
    endtask

    initial
    begin
        for (int i = 0; i < NUM_TIMERS; i++)
        begin
            tmr_count[i] = '0;
            tmr_armed[i] = 1'b0;
        end
        repeat (12) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: edge values, ignored starts and stops, reload, full-bank expiry
        queue_cmd(KIND_START, 8'd0, 32'd1);
        queue_cmd(KIND_START, 8'd7, 32'd2);
        queue_cmd(KIND_START, 8'd3, 32'd0);
        queue_cmd(KIND_START, 8'd8, 32'd1);
        queue_cmd(KIND_START, 8'd255, 32'hFFFF_FFFF);
        queue_cmd(KIND_TICK, 8'd255, 32'hFFFF_FFFF);
        queue_cmd(KIND_TICK, 8'd0, 32'd0);
        for (int i = 0; i < NUM_TIMERS; i++)
            queue_cmd(KIND_START, 8'(i), 32'd1);
        queue_cmd(KIND_TICK, 8'hA5, 32'h5A5A_A5A5);
        queue_cmd(KIND_START, 8'd2, 32'd5);
        queue_cmd(KIND_START, 8'd2, 32'd1);
        queue_cmd(KIND_STOP, 8'd6, 32'hFFFF_FFFF);
        queue_cmd(KIND_STOP, 8'd255, 32'd0);
        queue_cmd(KIND_START, 8'd4, 32'd3);
        queue_cmd(KIND_STOP, 8'd4, 32'd0);
        queue_cmd(KIND_START, 8'd5, 32'hFFFF_FFFF);
        queue_cmd(KIND_TICK, 8'h00, 32'h0000_0000);
        queue_cmd(KIND_CLEAR, 8'hFF, 32'hFFFF_FFFF);
        queue_cmd(KIND_TICK, 8'h5A, 32'hA5A5_5A5A);
        wait_drained();

        run_phase(0, 0, 35);
        run_phase(75, 0, 35);
        run_phase(0, 75, 35);
        run_phase(6, 6, 35);

        // pressure: receiver holds off while the bank fills with expiries
        send_idle_pct = 0;
        recv_stall_pct = 0;
        for (int r = 0; r < 2; r++)
        begin
            for (int i = 0; i < NUM_TIMERS; i++)
                queue_cmd(KIND_START, 8'(i), 32'(1 + r));
            queue_cmd(KIND_TICK, 8'd0, 32'd0);
        end
        queue_cmd(KIND_TICK, 8'd0, 32'd0);
        for (int i = 0; i < 20; i++)
            pending_cmds.push_back(make_random_cmd());
        hold_request = 1'b1;
        @(negedge clk);
        hold_request = 1'b0;
        wait_drained();

        repeat (40) @(negedge clk);
        $display("Run covered %0d commands, %0d of them ticks, and %0d expiry transactions",
                 cmds_done, ticks_done, expiries_seen);
        $display("under no idling, sender idling, receiver stalling, both, and a long hold-off");
        if (errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

### files.f
rtl/otsb_pkg.sv
rtl/one_shot_timer_bank_unit.sv
rtl/otsb_checker.sv
sim/testbench.sv
